@@ src/rslnk_pkg.sv @@
package rslnk_pkg;

  typedef enum logic [3:0] {
    OP_TICK     = 4'd0,
    OP_RX_BYTE  = 4'd1,
    OP_READ     = 4'd2,
    OP_FREE     = 4'd3,
    OP_PULL     = 4'd4,
    OP_TX_WRITE = 4'd5,
    OP_TX_START = 4'd6,
    OP_TX_SLOT  = 4'd7,
    OP_TX_DONE  = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    PH_RECV    = 2'd0,
    PH_BETWEEN = 2'd1,
    PH_READY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_RX   = 2'd1,
    SRC_TX   = 2'd2
  } src_t;

  localparam int CNT_GOOD    = 0;
  localparam int CNT_FLIP    = 1;
  localparam int CNT_OVF     = 2;
  localparam int CNT_TX_LONG = 3;

  localparam int OUT_CNT_W = 16;

  // Buffer access requested by one transaction.
  typedef struct packed {
    logic       rx_we;
    logic       rx_re;
    logic       tx_we;
    logic       tx_re;
    logic       rx_wbank;
    logic       rx_rbank;
    logic [7:0] rx_wpos;
    logic [7:0] tx_rpos;
  } mem_req_t;

  // Status of the link after one transaction.
  typedef struct packed {
    src_t       byte_src;
    logic       last_tx_byte;
    logic       frame_ready;
    logic [7:0] frame_length;
    phase_t     line_phase;
    logic       drive_enable;
    logic       tx_pending;
  } status_t;

endpackage

@@ src/rslnk_ctrl.sv @@
module rslnk_ctrl #(
  parameter int RX_DEPTH    = 128,
  parameter int TX_DEPTH    = 128,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [3:0]                     opcode,
  input  logic [6:0]                     buffer_index,
  input  logic [7:0]                     tx_length,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,
  output rslnk_pkg::mem_req_t            req,
  output rslnk_pkg::status_t             status,
  output logic [3:0][COUNT_WIDTH-1:0]    counts
);

  logic [7:0]              silence_ticks;
  logic                    back_select, back_select_next;
  logic                    front_held, front_held_next;
  logic [7:0]              front_length, front_length_next;
  logic [7:0]              rx_position, rx_position_next;
  logic                    rx_overflowed, rx_overflowed_next;
  rslnk_pkg::phase_t       phase, phase_next;
  logic [7:0]              silence_left, silence_left_next;
  logic                    timer_armed, timer_armed_next;
  logic [7:0]              tx_total, tx_total_next;
  logic [7:0]              tx_position, tx_position_next;
  logic                    tx_requested, tx_requested_next;
  logic                    driver_on, driver_on_next;
  logic                    feed_enabled, feed_enabled_next;
  logic [3:0][COUNT_WIDTH-1:0] cnt, cnt_next;

  logic [3:0]              bump;
  logic                    clear_cnts;
  logic [7:0]              silence_eff;
  logic [7:0]              silence_dec;
  logic [7:0]              idx_ext;
  rslnk_pkg::src_t         byte_src;
  logic                    last_byte;

  assign silence_eff = (silence_ticks == 8'd0) ? 8'd1 : silence_ticks;
  assign silence_dec = silence_left - 8'd1;
  assign idx_ext     = {1'b0, buffer_index};

  always_comb begin
    back_select_next   = back_select;
    front_held_next    = front_held;
    front_length_next  = front_length;
    rx_position_next   = rx_position;
    rx_overflowed_next = rx_overflowed;
    phase_next         = phase;
    silence_left_next  = silence_left;
    timer_armed_next   = timer_armed;
    tx_total_next      = tx_total;
    tx_position_next   = tx_position;
    tx_requested_next  = tx_requested;
    driver_on_next     = driver_on;
    feed_enabled_next  = feed_enabled;
    bump               = 4'b0000;
    clear_cnts         = 1'b0;
    byte_src           = rslnk_pkg::SRC_NONE;
    last_byte          = 1'b0;
    req                = '0;
    req.rx_wbank       = back_select;
    req.rx_rbank       = ~back_select;
    req.rx_wpos        = rx_position;
    req.tx_rpos        = tx_position;
    if (accept) begin
      case (rslnk_pkg::op_t'(opcode))
        rslnk_pkg::OP_TICK: begin
          if (timer_armed) begin
            silence_left_next = silence_dec;
            if (silence_dec == 8'd0) begin
              timer_armed_next = 1'b0;
              if (phase == rslnk_pkg::PH_RECV) begin
                // End of frame: re-arm for the inter-frame gap and close it.
                phase_next        = rslnk_pkg::PH_BETWEEN;
                silence_left_next = silence_eff;
                timer_armed_next  = 1'b1;
                if (rx_overflowed) begin
                  bump[rslnk_pkg::CNT_OVF] = 1'b1;
                end else if (front_held) begin
                  bump[rslnk_pkg::CNT_FLIP] = 1'b1;
                end else begin
                  bump[rslnk_pkg::CNT_GOOD] = 1'b1;
                  front_length_next = rx_position;
                  front_held_next   = 1'b1;
                  back_select_next  = ~back_select;
                end
                rx_position_next   = 8'd0;
                rx_overflowed_next = 1'b0;
              end else begin
                phase_next = rslnk_pkg::PH_READY;
                if (tx_requested) begin
                  driver_on_next    = 1'b1;
                  feed_enabled_next = 1'b1;
                end
              end
            end
          end
        end
        rslnk_pkg::OP_RX_BYTE: begin
          silence_left_next = silence_eff;
          timer_armed_next  = 1'b1;
          phase_next        = rslnk_pkg::PH_RECV;
          if (rx_overflowed || rx_position >= 8'(RX_DEPTH)) begin
            rx_overflowed_next = 1'b1;
          end else begin
            req.rx_we        = 1'b1;
            rx_position_next = rx_position + 8'd1;
          end
        end
        rslnk_pkg::OP_READ: begin
          if (front_held && idx_ext < front_length && idx_ext < 8'(RX_DEPTH)) begin
            req.rx_re = 1'b1;
            byte_src  = rslnk_pkg::SRC_RX;
          end
        end
        rslnk_pkg::OP_FREE: begin
          front_held_next = 1'b0;
        end
        rslnk_pkg::OP_PULL: begin
          clear_cnts = 1'b1;
        end
        rslnk_pkg::OP_TX_WRITE: begin
          req.tx_we = (idx_ext < 8'(TX_DEPTH));
        end
        rslnk_pkg::OP_TX_START: begin
          if (tx_length > 8'(TX_DEPTH)) begin
            bump[rslnk_pkg::CNT_TX_LONG] = 1'b1;
          end else if (tx_length != 8'd0) begin
            tx_total_next     = tx_length;
            tx_requested_next = 1'b1;
            if (phase == rslnk_pkg::PH_READY) begin
              driver_on_next    = 1'b1;
              feed_enabled_next = 1'b1;
            end
          end
        end
        rslnk_pkg::OP_TX_SLOT: begin
          if (feed_enabled && tx_position < tx_total && tx_position < 8'(TX_DEPTH)) begin
            req.tx_re = 1'b1;
            byte_src  = rslnk_pkg::SRC_TX;
            if ((tx_position + 8'd1) >= tx_total) begin
              last_byte         = 1'b1;
              feed_enabled_next = 1'b0;
            end
            tx_position_next = tx_position + 8'd1;
          end
        end
        rslnk_pkg::OP_TX_DONE: begin
          tx_position_next  = 8'd0;
          driver_on_next    = 1'b0;
          feed_enabled_next = 1'b0;
          tx_requested_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    for (int k = 0; k < 4; k++) begin
      cnt_next[k] = clear_cnts ? '0 : cnt[k] + COUNT_WIDTH'(bump[k]);
    end
  end

  // Status as it stands after the transaction; counter pull reports the values before the clear.
  always_comb begin
    status.byte_src     = byte_src;
    status.last_tx_byte = last_byte;
    status.frame_ready  = front_held_next;
    status.frame_length = front_held_next ? front_length_next : 8'd0;
    status.line_phase   = phase_next;
    status.drive_enable = driver_on_next;
    status.tx_pending   = tx_requested_next;
    counts              = clear_cnts ? cnt : cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_ticks <= 8'd4;
      back_select   <= 1'b0;
      front_held    <= 1'b0;
      front_length  <= 8'd0;
      rx_position   <= 8'd0;
      rx_overflowed <= 1'b0;
      phase         <= rslnk_pkg::PH_READY;
      silence_left  <= 8'd0;
      timer_armed   <= 1'b0;
      tx_total      <= 8'd0;
      tx_position   <= 8'd0;
      tx_requested  <= 1'b0;
      driver_on     <= 1'b0;
      feed_enabled  <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_we) begin
        silence_ticks <= cfg_wdata;
      end
      back_select   <= back_select_next;
      front_held    <= front_held_next;
      front_length  <= front_length_next;
      rx_position   <= rx_position_next;
      rx_overflowed <= rx_overflowed_next;
      phase         <= phase_next;
      silence_left  <= silence_left_next;
      timer_armed   <= timer_armed_next;
      tx_total      <= tx_total_next;
      tx_position   <= tx_position_next;
      tx_requested  <= tx_requested_next;
      driver_on     <= driver_on_next;
      feed_enabled  <= feed_enabled_next;
      cnt           <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_drive_needs_request: assert property (@(posedge clk) disable iff (rst)
    driver_on |-> tx_requested)
    else $error("driver on without a pending transmit");
  a_rx_pos_bound: assert property (@(posedge clk) disable iff (rst)
    rx_position <= 8'(RX_DEPTH))
    else $error("receive position beyond buffer");
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(req.rx_we && req.rx_re) && !(req.tx_we && req.tx_re))
    else $error("read and write of one buffer in one transaction");
`endif

endmodule

@@ src/rs485_silence_framed_link_top.sv @@
// Channel   Direction  tdata (low bit first)                          tuser         tlast
// s_*       in         data_byte, buffer_index, tx_length             opcode        -
// m_*       out        out_byte, frame_ready, frame_length,           byte_valid    last_tx_byte
//                      line_phase, drive_enable, tx_pending, good,
//                      held_drop, rx_overflow, tx_too_long counts
// cfg_*     in         cfg_wdata: silence_ticks                       -             -
// One input transaction is taken per cycle while s_tready is high; each gives one result.
// The rate is set by the single read port of each buffer memory, read at most once per transaction.
// Reset is synchronous; the buffer memories are not cleared and need no clearing pass.
// A stalled output holds one result in the output register and one in the read stage;
// s_tready falls only when both are full.
module rs485_silence_framed_link_top #(
  parameter int RX_DEPTH    = 128,
  parameter int TX_DEPTH    = 128,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], buffer_index[14:8], tx_length[22:15], zero
  input  logic [3:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // out_byte, frame_ready, frame_length, line_phase,
                                 // drive_enable, tx_pending, four 16-bit counts, zero
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast    // last_tx_byte
);

  localparam int RX_AW = $clog2(2 * RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);

  logic                        accept;
  rslnk_pkg::mem_req_t         req;
  rslnk_pkg::status_t          status;
  logic [3:0][COUNT_WIDTH-1:0] counts;

  logic [7:0]       rx_mem [2*RX_DEPTH];
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [7:0]       rx_q;
  logic [7:0]       tx_q;
  logic [RX_AW-1:0] rx_waddr;
  logic [RX_AW-1:0] rx_raddr;
  logic [TX_AW-1:0] tx_waddr;

  logic                        s1_valid;
  rslnk_pkg::status_t          s1_status;
  logic [3:0][COUNT_WIDTH-1:0] s1_counts;
  logic                        s1_adv;
  logic [7:0]                  s1_byte;

  logic        out_valid;
  logic [87:0] out_data;
  logic        out_user;
  logic        out_last;

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  rslnk_ctrl #(
    .RX_DEPTH    (RX_DEPTH),
    .TX_DEPTH    (TX_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (s_tuser),
    .buffer_index (s_tdata[14:8]),
    .tx_length    (s_tdata[22:15]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req          (req),
    .status       (status),
    .counts       (counts)
  );

  assign rx_waddr = req.rx_wbank ? RX_AW'(RX_DEPTH) + RX_AW'(req.rx_wpos) : RX_AW'(req.rx_wpos);
  assign rx_raddr = req.rx_rbank ? RX_AW'(RX_DEPTH) + RX_AW'(s_tdata[14:8])
                                 : RX_AW'(s_tdata[14:8]);
  assign tx_waddr = TX_AW'(s_tdata[14:8]);

  always_ff @(posedge clk) begin
    if (accept && req.rx_we) begin
      rx_mem[rx_waddr] <= s_tdata[7:0];
    end
    if (accept && req.rx_re) begin
      rx_q <= rx_mem[rx_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.tx_we) begin
      tx_mem[tx_waddr] <= s_tdata[7:0];
    end
    if (accept && req.tx_re) begin
      tx_q <= tx_mem[req.tx_rpos[TX_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status;
      s1_counts <= counts;
    end
  end

  always_comb begin
    case (s1_status.byte_src)
      rslnk_pkg::SRC_RX: s1_byte = rx_q;
      rslnk_pkg::SRC_TX: s1_byte = tx_q;
      default:           s1_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= {3'b000,
                   rslnk_pkg::OUT_CNT_W'(s1_counts[rslnk_pkg::CNT_TX_LONG]),
                   rslnk_pkg::OUT_CNT_W'(s1_counts[rslnk_pkg::CNT_OVF]),
                   rslnk_pkg::OUT_CNT_W'(s1_counts[rslnk_pkg::CNT_FLIP]),
                   rslnk_pkg::OUT_CNT_W'(s1_counts[rslnk_pkg::CNT_GOOD]),
                   s1_status.tx_pending,
                   s1_status.drive_enable,
                   s1_status.line_phase,
                   s1_status.frame_length,
                   s1_status.frame_ready,
                   s1_byte};
      out_user <= (s1_status.byte_src != rslnk_pkg::SRC_NONE);
      out_last <= s1_status.last_tx_byte;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid && out_valid && !m_tready)
    else $error("input stalled with room in the pipeline");
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction lost before the read stage");
  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("result lost between read stage and output register");
  a_status_drive: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (!s1_status.drive_enable || s1_status.tx_pending))
    else $error("driver reported on without a pending transmit");
`endif

endmodule
